>>> rtl/core/cs_pkg.sv
package cs_pkg;

  localparam int KEY_W     = 8;
  localparam int KEPT_W    = 7;
  localparam int CNT_W     = 7;
  localparam int CFG_IDX_W = 4;
  localparam int USER_W    = 2;

  localparam int KEY_BITS_DEF = 8;
  localparam int MAX_KEYS_DEF = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = CFG_IDX_W'(1);

  localparam logic [KEY_W-1:0] RANGE_LOW_RST  = '0;
  localparam logic [KEY_W-1:0] RANGE_HIGH_RST = '1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic use_idx;
    logic inc_wr;
    logic clear_wr;
    logic dr_load;
    logic ptr_clr;
    logic ptr_inc;
    logic emit;
    logic emit_empty;
    logic finish;
  } cs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ptr_last;
    logic last_item;
    logic set_empty;
    logic cnt_zero;
    logic kept_zero;
    logic out_free;
  } cs_stat_t;

endpackage

>>> rtl/core/cs_ctrl.sv
module cs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  cs_pkg::cs_stat_t  stat,
  output cs_pkg::cs_cmd_t   cmd
);
  import cs_pkg::*;

  typedef enum logic [8:0] {
    ST_CLEAR   = 9'b000000001,
    ST_IDLE    = 9'b000000010,
    ST_INC_RD  = 9'b000000100,
    ST_INC_WR  = 9'b000001000,
    ST_DR_RD   = 9'b000010000,
    ST_DR_LOAD = 9'b000100000,
    ST_DR_EMIT = 9'b001000000,
    ST_EMPTY   = 9'b010000000,
    ST_DONE    = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.ptr_last) begin
          cmd.ptr_clr = 1'b1;
          state_nxt   = ST_IDLE;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.take  = 1'b1;
          state_nxt = ST_INC_RD;
        end
      end
      ST_INC_RD: begin
        cmd.use_idx = 1'b1;
        state_nxt   = ST_INC_WR;
      end
      ST_INC_WR: begin
        cmd.use_idx = 1'b1;
        cmd.inc_wr  = 1'b1;
        if (!stat.last_item) begin
          state_nxt = ST_IDLE;
        end else if (stat.set_empty) begin
          state_nxt = ST_EMPTY;
        end else begin
          state_nxt = ST_DR_RD;
        end
      end
      ST_DR_RD: begin
        state_nxt = ST_DR_LOAD;
      end
      ST_DR_LOAD: begin
        // The bin count is taken and the bin zeroed for the next set.
        cmd.dr_load = 1'b1;
        state_nxt   = ST_DR_EMIT;
      end
      ST_DR_EMIT: begin
        if (stat.cnt_zero) begin
          if (stat.kept_zero || stat.ptr_last) begin
            state_nxt = ST_DONE;
          end else begin
            cmd.ptr_inc = 1'b1;
            state_nxt   = ST_DR_RD;
          end
        end else if (stat.out_free) begin
          cmd.emit = 1'b1;
        end
      end
      ST_EMPTY: begin
        if (stat.out_free) begin
          cmd.emit_empty = 1'b1;
          state_nxt      = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd.finish  = 1'b1;
        cmd.ptr_clr = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

>>> rtl/core/cs_datapath.sv
module cs_datapath #(
  parameter int KEY_BITS = cs_pkg::KEY_BITS_DEF,
  parameter int MAX_KEYS = cs_pkg::MAX_KEYS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cs_pkg::cs_cmd_t               cmd,
  output cs_pkg::cs_stat_t              stat,
  input  logic [cs_pkg::KEY_W-1:0]      in_key,
  input  logic                          in_last,
  input  logic                          cfg_valid,
  input  logic [cs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cs_pkg::KEY_W-1:0]      cfg_data,
  input  logic                          out_tready,
  output logic                          out_tvalid,
  output logic [cs_pkg::KEY_W-1:0]      out_tdata,
  output logic                          out_tlast,
  output logic [cs_pkg::USER_W-1:0]     out_tuser
);
  import cs_pkg::*;

  // Keys are 8 bits wide, so bins past 255 can never be filled.
  localparam int IW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int NB = 1 << IW;

  logic [CNT_W-1:0]  mem [NB];
  logic [CNT_W-1:0]  rd_data_r;
  logic [IW-1:0]     mem_addr;
  logic              mem_we;
  logic [CNT_W-1:0]  mem_wdata;

  logic [KEY_W-1:0]  range_low_r, range_high_r;
  logic [KEPT_W-1:0] kept_r;
  logic              dropped_r;
  logic [IW-1:0]     ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [IW-1:0]     idx_r;
  logic              keep_r;
  logic              last_r;
  logic              out_valid_r;
  logic [KEY_W-1:0]  out_value_r;
  logic              out_last_r;
  logic              out_empty_r;
  logic              out_drop_r;

  logic [KEY_W-1:0]  idx_full;
  logic              keep;

  // Bin index is only meaningful when the key is not below the window.
  assign idx_full = in_key - range_low_r;
  assign keep     = (in_key >= range_low_r) && (in_key <= range_high_r)
                 && ((idx_full >> IW) == '0)
                 && (kept_r < KEPT_W'(MAX_KEYS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= RANGE_LOW_RST;
      range_high_r <= RANGE_HIGH_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RANGE_LOW:  range_low_r  <= cfg_data;
        CFG_RANGE_HIGH: range_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      idx_r  <= IW'(idx_full);
      keep_r <= keep;
      last_r <= in_last;
    end
  end

  assign mem_addr  = cmd.use_idx ? idx_r : ptr_r;
  assign mem_we    = cmd.clear_wr || cmd.dr_load || (cmd.inc_wr && keep_r);
  assign mem_wdata = cmd.inc_wr ? (rd_data_r + CNT_W'(1)) : '0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else if (cmd.ptr_clr) begin
      ptr_r <= '0;
    end else if (cmd.ptr_inc) begin
      ptr_r <= ptr_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dr_load) begin
      cnt_r <= rd_data_r;
    end else if (cmd.emit) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_r    <= '0;
      dropped_r <= 1'b0;
    end else begin
      if (cmd.inc_wr && keep_r) begin
        kept_r <= kept_r + KEPT_W'(1);
      end else if (cmd.emit) begin
        kept_r <= kept_r - KEPT_W'(1);
      end
      if (cmd.finish) begin
        dropped_r <= 1'b0;
      end else if (cmd.take && !keep) begin
        dropped_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.emit_empty) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_value_r <= range_low_r + KEY_W'(ptr_r);
      out_last_r  <= (kept_r == KEPT_W'(1));
      out_empty_r <= 1'b0;
      out_drop_r  <= dropped_r;
    end else if (cmd.emit_empty) begin
      out_value_r <= '0;
      out_last_r  <= 1'b1;
      out_empty_r <= 1'b1;
      out_drop_r  <= dropped_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_drop_r, out_empty_r};

  assign stat.ptr_last  = (ptr_r == IW'(NB - 1));
  assign stat.last_item = last_r;
  assign stat.set_empty = (kept_r == '0) && !keep_r;
  assign stat.cnt_zero  = (cnt_r == '0);
  assign stat.kept_zero = (kept_r == '0);
  assign stat.out_free  = !out_valid_r || out_tready;

endmodule

>>> rtl/core/counting_sort.sv
// Counting sort of 8-bit keys. Keys inside the range_low..range_high window
// are counted into a histogram of 2^min(KEY_BITS,8) bins held in a
// single-port memory; keys outside the window or past MAX_KEYS are dropped
// and reported in keys_dropped on every result of the set. An item with
// in_tlast set closes the set and the bins are walked in ascending order,
// one result per stored key, the final one with out_tlast; an empty set
// gives one result with empty_set set and value zero. After reset the block
// zeroes the histogram, one bin per cycle, with in_tready low. A new key is
// taken only after the read-modify-write of the last one's bin through the
// one memory port. The drain walks the bins in order up to the highest
// filled bin, holding each result while the output is not free; bins are
// zeroed as they are read. Configuration writes are always accepted and
// must only be made while the block is idle.
module counting_sort #(
  parameter int KEY_BITS = cs_pkg::KEY_BITS_DEF,
  parameter int MAX_KEYS = cs_pkg::MAX_KEYS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [cs_pkg::KEY_W-1:0]      in_tdata,   // [7:0] key_value
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [cs_pkg::KEY_W-1:0]      out_tdata,  // [7:0] sorted_value
  output logic                          out_tlast,
  output logic [cs_pkg::USER_W-1:0]     out_tuser,  // [0] empty_set, [1] keys_dropped
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cs_pkg::KEY_W-1:0]      cfg_data
);
  import cs_pkg::*;

  cs_cmd_t  cmd;
  cs_stat_t stat;

  assign cfg_ready = 1'b1;

  cs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cs_datapath #(
    .KEY_BITS (KEY_BITS),
    .MAX_KEYS (MAX_KEYS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_key     (in_tdata),
    .in_last    (in_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

>>> sim/counting_sort_tb.sv
module counting_sort_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cs_pkg::*;

  localparam int NUM_BINS    = 256;
  localparam int KEEP_MAX    = MAX_KEYS_DEF;
  localparam int QUIET_LIMIT = 6000;
  localparam int RAND_ITEMS  = 10;

  typedef struct packed {
    logic [KEY_W-1:0] value;
    logic             last;
    logic             empty;
    logic             dropped;
  } sorted_rec_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [KEY_W-1:0]     in_tdata;
  logic                 in_tlast;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [KEY_W-1:0]     out_tdata;
  logic                 out_tlast;
  logic [USER_W-1:0]    out_tuser;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [KEY_W-1:0]     cfg_data;

  // Predictor state: the histogram and window as the block should hold them.
  logic [CNT_W-1:0] bin_tab [NUM_BINS];
  int               kept_n;
  logic             drop_seen;
  logic [KEY_W-1:0] win_lo;
  logic [KEY_W-1:0] win_hi;

  sorted_rec_t sorted_q [$];

  int  n_errors;
  int  n_items;
  int  n_results;
  int  n_sets;
  int  n_empty_sets;
  int  n_dropped_sets;
  int  n_cfg;
  int  quiet_cycles;
  int  hold_left;
  int  stall_left;
  bit  stall_on;
  bit  gaps_on;

  counting_sort uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic void clear_hist();
    for (int j = 0; j < NUM_BINS; j++) bin_tab[j] = '0;
    kept_n    = 0;
    drop_seen = 1'b0;
  endfunction

  // Count one accepted key and, on the closing item, queue the sorted run.
  function automatic void tally_key(logic [KEY_W-1:0] key, logic last);
    int          idx;
    int          emitted;
    sorted_rec_t rec;
    if (key < win_lo || key > win_hi || kept_n >= KEEP_MAX) begin
      drop_seen = 1'b1;
    end else begin
      idx = int'(key) - int'(win_lo);
      bin_tab[idx] = bin_tab[idx] + 1'b1;
      kept_n++;
    end
    if (!last) return;
    n_sets++;
    if (drop_seen) n_dropped_sets++;
    if (kept_n == 0) begin
      rec = '{value: '0, last: 1'b1, empty: 1'b1, dropped: drop_seen};
      sorted_q.insert(sorted_q.size(), rec);
      n_empty_sets++;
    end else begin
      emitted = 0;
      for (int j = 0; j < NUM_BINS; j++) begin
        for (int c = 0; c < int'(bin_tab[j]); c++) begin
          emitted++;
          rec.value   = KEY_W'(int'(win_lo) + j);
          rec.last    = (emitted == kept_n);
          rec.empty   = 1'b0;
          rec.dropped = drop_seen;
          sorted_q.insert(sorted_q.size(), rec);
        end
      end
    end
    clear_hist();
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_key(logic [KEY_W-1:0] key, logic last);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = key;
    in_tlast  = last;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    n_items++;
    tally_key(key, last);
  endtask

  // Let every queued result arrive, then give the block time to close the set.
  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sorted_q.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [KEY_W-1:0] val);
    @(negedge clk);
    in_tvalid = 1'b0;
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    n_cfg++;
    if (idx == CFG_RANGE_LOW) win_lo = val;
    else if (idx == CFG_RANGE_HIGH) win_hi = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_window(logic [KEY_W-1:0] lo, logic [KEY_W-1:0] hi);
    write_reg(CFG_RANGE_LOW, lo);
    write_reg(CFG_RANGE_HIGH, hi);
  endtask

  task automatic test_reset_window();
    send_key(8'd0, 1'b1);
    send_key(8'd255, 1'b0);
    send_key(8'd0, 1'b0);
    send_key(8'd128, 1'b0);
    send_key(8'd0, 1'b0);
    send_key(8'd255, 1'b1);
    settle();
  endtask

  task automatic test_window_edges();
    set_window(8'd10, 8'd20);
    send_key(8'd9, 1'b0);
    send_key(8'd21, 1'b0);
    send_key(8'd20, 1'b0);
    send_key(8'd10, 1'b0);
    send_key(8'd15, 1'b1);
    // A set whose only key misses the window comes back as a single empty item.
    send_key(8'd5, 1'b1);
    settle();
    set_window(8'd200, 8'd100);
    send_key(8'd150, 1'b0);
    send_key(8'd200, 1'b0);
    send_key(8'd100, 1'b1);
    settle();
    set_window(8'd255, 8'd255);
    send_key(8'd255, 1'b0);
    send_key(8'd254, 1'b1);
    settle();
  endtask

  // Bins keep their index when range_low moves mid-set; the drain adds the
  // new low bound and wraps to eight bits.
  task automatic test_midset_change();
    set_window(8'd0, 8'd255);
    send_key(8'd250, 1'b0);
    send_key(8'd60, 1'b0);
    settle();
    write_reg(CFG_RANGE_LOW, 8'd10);
    send_key(8'd45, 1'b1);
    settle();
  endtask

  task automatic test_unused_index();
    for (int i = 2; i < 16; i++) write_reg(CFG_IDX_W'(i), 8'($urandom));
    send_key(8'd3, 1'b0);
    send_key(8'd1, 1'b1);
    settle();
  endtask

  task automatic test_capacity();
    set_window(8'd0, 8'd255);
    for (int i = 0; i < KEEP_MAX + 2; i++) begin
      send_key(8'($urandom), i == KEEP_MAX + 1);
    end
    settle();
  endtask

  task automatic test_backpressure();
    for (int i = 0; i < 6; i++) send_key(8'($urandom_range(0, 255)), i == 5);
    hold_left = 400;
    for (int i = 0; i < 8; i++) send_key(8'($urandom_range(0, 255)), i == 7);
    settle();
  endtask

  task automatic test_random_sets();
    int               target;
    int               len;
    logic [KEY_W-1:0] lo;
    logic [KEY_W-1:0] hi;
    logic [KEY_W-1:0] key;
    target = n_items + RAND_ITEMS;
    while (n_items < target) begin
      case ($urandom_range(0, 7))
        0: set_window(8'd0, 8'd255);
        1: set_window(8'd0, 8'd0);
        2: set_window(8'd255, 8'd255);
        3: set_window(8'($urandom), 8'($urandom));
        4: write_reg(CFG_IDX_W'($urandom_range(2, 15)), 8'($urandom));
        default: begin
          lo = 8'($urandom);
          hi = 8'($urandom_range(255, int'(lo)));
          set_window(lo, hi);
        end
      endcase
      gaps_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 12);
      if (len > target - n_items) len = target - n_items;
      for (int i = 0; i < len; i++) begin
        if (win_lo <= win_hi && $urandom_range(0, 9) < 8) begin
          key = 8'($urandom_range(int'(win_hi), int'(win_lo)));
        end else begin
          key = 8'($urandom);
        end
        send_key(key, i == len - 1);
      end
      settle();
    end
    gaps_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  // Result side: random stalls, plus a long hold when a test asks for one.
  always begin
    @(negedge clk);
    if (hold_left > 0) begin
      out_tready = 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_tready = 1'b0;
      stall_left--;
    end else begin
      out_tready = 1'b1;
      if (stall_on && $urandom_range(0, 99) < 20) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    sorted_rec_t want;
    sorted_rec_t got;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      got = '{value: out_tdata, last: out_tlast, empty: out_tuser[0],
              dropped: out_tuser[1]};
      if (sorted_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected item: value %0d last %0b empty %0b dropped %0b",
                   got.value, got.last, got.empty, got.dropped);
      end else begin
        want = sorted_q[0];
        sorted_q.delete(0);
        if (got != want) begin
          n_errors++;
          if (n_errors <= 10) begin
            $write("mismatch: expected value %0d last %0b empty %0b dropped %0b, ",
                   want.value, want.last, want.empty, want.dropped);
            $display("got value %0d last %0b empty %0b dropped %0b",
                     got.value, got.last, got.empty, got.dropped);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles, %0d items still expected",
               quiet_cycles, sorted_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tlast       = 1'b0;
    out_tready     = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    n_errors       = 0;
    n_items        = 0;
    n_results      = 0;
    n_sets         = 0;
    n_empty_sets   = 0;
    n_dropped_sets = 0;
    n_cfg          = 0;
    quiet_cycles   = 0;
    hold_left      = 0;
    stall_left     = 0;
    stall_on       = 1'b1;
    gaps_on        = 1'b1;
    win_lo         = RANGE_LOW_RST;
    win_hi         = RANGE_HIGH_RST;
    clear_hist();
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    // The histogram is zeroed after reset; wait for the input to open.
    do @(posedge clk); while (!in_tready);

    test_reset_window();
    test_window_edges();
    test_midset_change();
    test_unused_index();
    test_capacity();
    test_backpressure();
    test_random_sets();

    settle();
    repeat (20) @(posedge clk);
    $display("covered %0d items in %0d sets (%0d empty, %0d with drops), %0d results",
             n_items, n_sets, n_empty_sets, n_dropped_sets, n_results);
    $display("%0d register writes, windows from full to single key and inverted, %0d errors",
             n_cfg, n_errors);
    if (n_errors == 0 && sorted_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
